// ===== hw/rtl/rwps_pkg.sv =====
package rwps_pkg;

    localparam int unsigned CHAN_MAX = 8;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    typedef enum logic [3:0] {
        PH_RIFF  = 4'd0,
        PH_RSIZE = 4'd1,
        PH_WAVE  = 4'd2,
        PH_FMT   = 4'd3,
        PH_FSIZE = 4'd4,
        PH_FCODE = 4'd5,
        PH_CHAN  = 4'd6,
        PH_RATE  = 4'd7,
        PH_BRATE = 4'd8,
        PH_ALIGN = 4'd9,
        PH_BITS  = 4'd10,
        PH_SKIP  = 4'd11,
        PH_CTAG  = 4'd12,
        PH_CSIZE = 4'd13,
        PH_DSIZE = 4'd14,
        PH_DATA  = 4'd15
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_FORMAT = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_RIFF  = 3'd1,
        ERR_WAVE  = 3'd2,
        ERR_FMT   = 3'd3,
        ERR_PCM   = 3'd4,
        ERR_TRUNC = 3'd5,
        ERR_UNSUP = 3'd6
    } t_err;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] sample_value;
        logic [2:0]         channel_index;
        logic [3:0]         channels;
        logic [31:0]        sample_rate;
        logic [4:0]         sample_bits;
        t_err               error_code;
        logic               last;
    } t_result;

    function automatic logic [2:0] field_len(input t_phase ph);
        logic [2:0] len;
        case (ph)
            PH_FCODE, PH_CHAN, PH_ALIGN, PH_BITS: len = 3'd2;
            default:                              len = 3'd4;
        endcase
        return len;
    endfunction

endpackage

// ===== hw/rtl/rwps_parse.sv =====
module rwps_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_eos,
    output logic             o_res_valid,
    output rwps_pkg::t_result o_res
);

    rwps_pkg::t_phase r_phase, n_phase;
    logic [31:0] r_shift, n_shift;
    logic [1:0]  r_cnt, n_cnt;
    logic [31:0] r_skip, n_skip;
    logic [3:0]  r_chan_total, n_chan_total;
    logic [31:0] r_rate, n_rate;
    logic [4:0]  r_width, n_width;
    logic [31:0] r_remain, n_remain;
    logic [2:0]  r_cur_chan, n_cur_chan;
    logic        r_err, n_err;
    logic        r_done, n_done;

    logic [31:0] acc;
    logic [2:0]  cnt_inc;
    logic [1:0]  nbytes;
    logic [5:0]  frame;
    logic [31:0] remain_new;
    logic        wrap;
    logic        finished;
    logic        done_now;
    logic        res_v;
    rwps_pkg::t_result res;

    always_comb begin
        acc        = r_shift | ({24'd0, i_byte} << {r_cnt, 3'b000});
        cnt_inc    = {1'b0, r_cnt} + 3'd1;
        nbytes     = r_width[4:3];
        frame      = 6'(r_chan_total) * 6'(nbytes);
        remain_new = r_remain - {30'd0, nbytes};
        wrap       = ({1'b0, r_cur_chan} + 4'd1) >= r_chan_total;
        finished   = r_err | ((r_phase == rwps_pkg::PH_DATA) & r_done);

        n_phase      = r_phase;
        n_shift      = r_shift;
        n_cnt        = r_cnt;
        n_skip       = r_skip;
        n_chan_total = r_chan_total;
        n_rate       = r_rate;
        n_width      = r_width;
        n_remain     = r_remain;
        n_cur_chan   = r_cur_chan;
        n_err        = r_err;
        n_done       = r_done;
        res_v        = 1'b0;
        res          = '0;

        if (!finished) begin
            case (r_phase)
                rwps_pkg::PH_SKIP: begin
                    n_skip = r_skip - 32'd1;
                    if (r_skip == 32'd1) begin
                        n_phase = rwps_pkg::PH_CTAG;
                    end
                end
                rwps_pkg::PH_DATA: begin
                    n_shift = acc;
                    n_cnt   = cnt_inc[1:0];
                    if (cnt_inc == {1'b0, nbytes}) begin
                        n_shift = '0;
                        n_cnt   = '0;
                        res_v   = 1'b1;
                        res.kind = rwps_pkg::KIND_SAMPLE;
                        case (nbytes)
                            2'd1:    res.sample_value = {~acc[7], acc[6:0], 24'd0};
                            2'd2:    res.sample_value = {acc[15:0], 16'd0};
                            default: res.sample_value = {acc[23:0], 8'd0};
                        endcase
                        res.channel_index = r_cur_chan;
                        n_remain   = remain_new;
                        res.last   = wrap & (remain_new < {26'd0, frame});
                        n_done     = res.last;
                        n_cur_chan = wrap ? 3'd0 : r_cur_chan + 3'd1;
                    end
                end
                default: begin
                    n_shift = acc;
                    n_cnt   = cnt_inc[1:0];
                    if (cnt_inc >= rwps_pkg::field_len(r_phase)) begin
                        n_shift = '0;
                        n_cnt   = '0;
                        case (r_phase)
                            rwps_pkg::PH_RIFF: begin
                                if (acc != rwps_pkg::TAG_RIFF) begin
                                    res_v = 1'b1;
                                    res.kind = rwps_pkg::KIND_ERROR;
                                    res.error_code = rwps_pkg::ERR_RIFF;
                                    res.last = 1'b1;
                                    n_err = 1'b1;
                                end else begin
                                    n_phase = rwps_pkg::PH_RSIZE;
                                end
                            end
                            rwps_pkg::PH_RSIZE: n_phase = rwps_pkg::PH_WAVE;
                            rwps_pkg::PH_WAVE: begin
                                if (acc != rwps_pkg::TAG_WAVE) begin
                                    res_v = 1'b1;
                                    res.kind = rwps_pkg::KIND_ERROR;
                                    res.error_code = rwps_pkg::ERR_WAVE;
                                    res.last = 1'b1;
                                    n_err = 1'b1;
                                end else begin
                                    n_phase = rwps_pkg::PH_FMT;
                                end
                            end
                            rwps_pkg::PH_FMT: begin
                                if (acc != rwps_pkg::TAG_FMT) begin
                                    res_v = 1'b1;
                                    res.kind = rwps_pkg::KIND_ERROR;
                                    res.error_code = rwps_pkg::ERR_FMT;
                                    res.last = 1'b1;
                                    n_err = 1'b1;
                                end else begin
                                    n_phase = rwps_pkg::PH_FSIZE;
                                end
                            end
                            rwps_pkg::PH_FSIZE: begin
                                n_skip  = (acc > 32'd16) ? acc - 32'd16 + {31'd0, acc[0]}
                                                         : 32'd0;
                                n_phase = rwps_pkg::PH_FCODE;
                            end
                            rwps_pkg::PH_FCODE: begin
                                if (acc != 32'd1) begin
                                    res_v = 1'b1;
                                    res.kind = rwps_pkg::KIND_ERROR;
                                    res.error_code = rwps_pkg::ERR_PCM;
                                    res.last = 1'b1;
                                    n_err = 1'b1;
                                end else begin
                                    n_phase = rwps_pkg::PH_CHAN;
                                end
                            end
                            rwps_pkg::PH_CHAN: begin
                                if (acc == 32'd0 || acc > 32'(rwps_pkg::CHAN_MAX)) begin
                                    res_v = 1'b1;
                                    res.kind = rwps_pkg::KIND_ERROR;
                                    res.error_code = rwps_pkg::ERR_UNSUP;
                                    res.last = 1'b1;
                                    n_err = 1'b1;
                                end else begin
                                    n_chan_total = acc[3:0];
                                    n_phase      = rwps_pkg::PH_RATE;
                                end
                            end
                            rwps_pkg::PH_RATE: begin
                                n_rate  = acc;
                                n_phase = rwps_pkg::PH_BRATE;
                            end
                            rwps_pkg::PH_BRATE: n_phase = rwps_pkg::PH_ALIGN;
                            rwps_pkg::PH_ALIGN: n_phase = rwps_pkg::PH_BITS;
                            rwps_pkg::PH_BITS: begin
                                if (acc != 32'd8 && acc != 32'd16 && acc != 32'd24) begin
                                    res_v = 1'b1;
                                    res.kind = rwps_pkg::KIND_ERROR;
                                    res.error_code = rwps_pkg::ERR_UNSUP;
                                    res.last = 1'b1;
                                    n_err = 1'b1;
                                end else begin
                                    n_width = acc[4:0];
                                    n_phase = (r_skip == 32'd0) ? rwps_pkg::PH_CTAG
                                                                : rwps_pkg::PH_SKIP;
                                end
                            end
                            rwps_pkg::PH_CTAG: begin
                                n_phase = (acc == rwps_pkg::TAG_DATA) ? rwps_pkg::PH_DSIZE
                                                                      : rwps_pkg::PH_CSIZE;
                            end
                            rwps_pkg::PH_CSIZE: begin
                                n_skip  = (acc[0] && acc != 32'hFFFF_FFFF) ? acc + 32'd1 : acc;
                                n_phase = (acc == 32'd0) ? rwps_pkg::PH_CTAG
                                                         : rwps_pkg::PH_SKIP;
                            end
                            rwps_pkg::PH_DSIZE: begin
                                if (frame == 6'd0) begin
                                    res_v = 1'b1;
                                    res.kind = rwps_pkg::KIND_ERROR;
                                    res.error_code = rwps_pkg::ERR_UNSUP;
                                    res.last = 1'b1;
                                    n_err = 1'b1;
                                end else begin
                                    n_remain   = acc;
                                    n_cur_chan = 3'd0;
                                    n_done     = acc < {26'd0, frame};
                                    n_phase    = rwps_pkg::PH_DATA;
                                    res_v           = 1'b1;
                                    res.kind        = rwps_pkg::KIND_FORMAT;
                                    res.channels    = r_chan_total;
                                    res.sample_rate = r_rate;
                                    res.sample_bits = r_width;
                                    res.last        = acc < {26'd0, frame};
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            endcase
        end

        done_now = n_err | ((n_phase == rwps_pkg::PH_DATA) & n_done);

        if (i_eos) begin
            if (!(res_v && res.last) && !done_now) begin
                res_v = 1'b1;
                res   = '0;
                res.kind       = rwps_pkg::KIND_ERROR;
                res.error_code = rwps_pkg::ERR_TRUNC;
                res.last       = 1'b1;
            end
            n_phase      = rwps_pkg::PH_RIFF;
            n_shift      = '0;
            n_cnt        = '0;
            n_skip       = '0;
            n_chan_total = '0;
            n_rate       = '0;
            n_width      = '0;
            n_remain     = '0;
            n_cur_chan   = '0;
            n_err        = 1'b0;
            n_done       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= rwps_pkg::PH_RIFF;
            r_shift      <= '0;
            r_cnt        <= '0;
            r_skip       <= '0;
            r_chan_total <= '0;
            r_rate       <= '0;
            r_width      <= '0;
            r_remain     <= '0;
            r_cur_chan   <= '0;
            r_err        <= 1'b0;
            r_done       <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_shift      <= n_shift;
            r_cnt        <= n_cnt;
            r_skip       <= n_skip;
            r_chan_total <= n_chan_total;
            r_rate       <= n_rate;
            r_width      <= n_width;
            r_remain     <= n_remain;
            r_cur_chan   <= n_cur_chan;
            r_err        <= n_err;
            r_done       <= n_done;
        end
    end

    assign o_res_valid = i_accept & res_v;
    assign o_res       = res;

endmodule

// ===== hw/rtl/rwps_skid.sv =====
module rwps_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  rwps_pkg::t_result i_in_data,
    output logic              o_full,
    output logic              o_valid,
    output rwps_pkg::t_result o_data,
    input  logic              i_stall
);

    logic              r_valid;
    logic              r_skid_valid;
    rwps_pkg::t_result r_data;
    rwps_pkg::t_result r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid      <= r_skid_valid | i_in_valid;
            r_skid_valid <= 1'b0;
        end else if (i_in_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_valid || !i_stall) begin
            r_data <= r_skid_valid ? r_skid : i_in_data;
        end else if (i_in_valid) begin
            r_skid <= i_in_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hw/rtl/riff_wave_pcm_stream_parser_unit.sv =====
// A result is formed combinationally from its byte and registered in the output buffer.
// Throughput: one byte per cycle unless stalled; the single-pass step updates all state.
// A two-entry output buffer keeps bytes flowing while one result waits downstream.
// Reset (synchronous, active low) returns the parser to the RIFF tag and empties
// the output buffer; an end-of-stream beat does the same to the parser state.
module riff_wave_pcm_stream_parser_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_in_byte,
    input  logic               i_end_of_stream,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic signed [31:0] o_sample_value,
    output logic [2:0]         o_channel_index,
    output logic [3:0]         o_channels,
    output logic [31:0]        o_sample_rate,
    output logic [4:0]         o_sample_bits,
    output logic [2:0]         o_error_code,
    output logic               o_last
);

    logic              accept;
    logic              res_valid;
    logic              buf_full;
    rwps_pkg::t_result res;
    rwps_pkg::t_result out;

    assign accept  = i_valid & ~buf_full;
    assign o_stall = buf_full;

    rwps_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_in_byte),
        .i_eos       (i_end_of_stream),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rwps_skid u_skid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (res_valid),
        .i_in_data  (res),
        .o_full     (buf_full),
        .o_valid    (o_valid),
        .o_data     (out),
        .i_stall    (i_stall)
    );

    assign o_kind          = out.kind;
    assign o_sample_value  = out.sample_value;
    assign o_channel_index = out.channel_index;
    assign o_channels      = out.channels;
    assign o_sample_rate   = out.sample_rate;
    assign o_sample_bits   = out.sample_bits;
    assign o_error_code    = out.error_code;
    assign o_last          = out.last;

endmodule

// ===== sim/riff_wave_pcm_stream_parser_unit_test.sv =====
`timescale 1ns / 1ps

module riff_wave_pcm_stream_parser_unit_test;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_BYTES = 720;
    localparam logic [7:0] RAIL_BYTES [5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};

    typedef struct {
        int             bad_tag;
        logic [31:0]    fsize;
        logic [15:0]    code;
        logic [15:0]    chans;
        logic [31:0]    rate;
        logic [15:0]    bits;
        bit             junk;
        logic [31:0]    jsize;
        logic [31:0]    dsize;
        int             dbytes;
        int             cut;
        rwps_pkg::t_err typed;
    } t_wav_spec;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [7:0]         i_in_byte = 8'h00;
    logic               i_end_of_stream = 1'b0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_kind;
    logic signed [31:0] o_sample_value;
    logic [2:0]         o_channel_index;
    logic [3:0]         o_channels;
    logic [31:0]        o_sample_rate;
    logic [4:0]         o_sample_bits;
    logic [2:0]         o_error_code;
    logic               o_last;

    rwps_pkg::t_phase wav_phase;
    logic [31:0]      wav_shift;
    logic [2:0]       wav_count;
    logic [31:0]      wav_skip;
    logic [3:0]       wav_chans;
    logic [31:0]      wav_rate;
    logic [4:0]       wav_bits;
    logic [31:0]      wav_left;
    logic [2:0]       wav_chan;
    bit               wav_dead;

    rwps_pkg::t_result pending_results[$];
    logic [7:0]        file_q[$];
    int                mismatches = 0;
    int                bytes_sent = 0;
    int                cycles = 0;
    bit                burst = 1'b0;
    rwps_pkg::t_err    row_fault = rwps_pkg::ERR_NONE;

    riff_wave_pcm_stream_parser_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_in_byte       (i_in_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_sample_value  (o_sample_value),
        .o_channel_index (o_channel_index),
        .o_channels      (o_channels),
        .o_sample_rate   (o_sample_rate),
        .o_sample_bits   (o_sample_bits),
        .o_error_code    (o_error_code),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void wav_reset();
        wav_phase = rwps_pkg::PH_RIFF;
        wav_shift = '0;
        wav_count = '0;
        wav_skip  = '0;
        wav_chans = '0;
        wav_rate  = '0;
        wav_bits  = '0;
        wav_left  = '0;
        wav_chan  = '0;
        wav_dead  = 1'b0;
    endfunction

    function automatic rwps_pkg::t_result fault_beat(input rwps_pkg::t_err code);
        rwps_pkg::t_result r;
        r            = '0;
        r.kind       = rwps_pkg::KIND_ERROR;
        r.error_code = code;
        r.last       = 1'b1;
        return r;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input bit eos,
                                      output rwps_pkg::t_result r);
        logic [31:0]    v;
        logic [31:0]    sz;
        logic [31:0]    frame;
        logic [31:0]    s;
        logic [3:0]     nxt;
        logic [2:0]     n;
        rwps_pkg::t_err fault;
        bit             have;
        have  = 1'b0;
        fault = rwps_pkg::ERR_NONE;
        r     = '0;
        if (!(wav_dead || (wav_phase == rwps_pkg::PH_DATA && wav_left == 0))) begin
            if (wav_phase == rwps_pkg::PH_SKIP) begin
                wav_skip = wav_skip - 1;
                if (wav_skip == 0) wav_phase = rwps_pkg::PH_CTAG;
            end else begin
                wav_shift = wav_shift | (32'(b) << (8 * wav_count[1:0]));
                wav_count = wav_count + 3'd1;
                if (wav_phase == rwps_pkg::PH_DATA) begin
                    n = 3'(wav_bits >> 3);
                end else if (wav_phase == rwps_pkg::PH_FCODE || wav_phase == rwps_pkg::PH_CHAN ||
                             wav_phase == rwps_pkg::PH_ALIGN || wav_phase == rwps_pkg::PH_BITS) begin
                    n = 3'd2;
                end else begin
                    n = 3'd4;
                end
                if (wav_count >= n) begin
                    v = wav_shift;
                    wav_shift = '0;
                    wav_count = '0;
                    if (wav_phase == rwps_pkg::PH_DATA) begin
                        case (n)
                            3'd1:    s = {v[7:0] ^ 8'h80, 24'h0};
                            3'd2:    s = {v[15:0], 16'h0};
                            default: s = {v[23:0], 8'h0};
                        endcase
                        have            = 1'b1;
                        r.kind          = rwps_pkg::KIND_SAMPLE;
                        r.sample_value  = s;
                        r.channel_index = wav_chan;
                        wav_left = (wav_left >= n) ? wav_left - n : '0;
                        r.last   = (wav_left == 0);
                        nxt      = {1'b0, wav_chan} + 4'd1;
                        wav_chan = (nxt >= wav_chans) ? 3'd0 : nxt[2:0];
                    end else begin
                        case (wav_phase)
                            rwps_pkg::PH_RIFF: begin
                                if (v != rwps_pkg::TAG_RIFF) fault = rwps_pkg::ERR_RIFF;
                                else wav_phase = rwps_pkg::PH_RSIZE;
                            end
                            rwps_pkg::PH_RSIZE: wav_phase = rwps_pkg::PH_WAVE;
                            rwps_pkg::PH_WAVE: begin
                                if (v != rwps_pkg::TAG_WAVE) fault = rwps_pkg::ERR_WAVE;
                                else wav_phase = rwps_pkg::PH_FMT;
                            end
                            rwps_pkg::PH_FMT: begin
                                if (v != rwps_pkg::TAG_FMT) fault = rwps_pkg::ERR_FMT;
                                else wav_phase = rwps_pkg::PH_FSIZE;
                            end
                            rwps_pkg::PH_FSIZE: begin
                                wav_skip = (v > 16) ? v - 16 : '0;
                                if (v[0] && v > 16 && wav_skip != '1) wav_skip = wav_skip + 1;
                                wav_phase = rwps_pkg::PH_FCODE;
                            end
                            rwps_pkg::PH_FCODE: begin
                                if (v != 1) fault = rwps_pkg::ERR_PCM;
                                else wav_phase = rwps_pkg::PH_CHAN;
                            end
                            rwps_pkg::PH_CHAN: begin
                                if (v == 0 || v > rwps_pkg::CHAN_MAX) begin
                                    fault = rwps_pkg::ERR_UNSUP;
                                end else begin
                                    wav_chans = v[3:0];
                                    wav_phase = rwps_pkg::PH_RATE;
                                end
                            end
                            rwps_pkg::PH_RATE: begin
                                wav_rate  = v;
                                wav_phase = rwps_pkg::PH_BRATE;
                            end
                            rwps_pkg::PH_BRATE: wav_phase = rwps_pkg::PH_ALIGN;
                            rwps_pkg::PH_ALIGN: wav_phase = rwps_pkg::PH_BITS;
                            rwps_pkg::PH_BITS: begin
                                if (!(v == 8 || v == 16 || v == 24)) begin
                                    fault = rwps_pkg::ERR_UNSUP;
                                end else begin
                                    wav_bits  = v[4:0];
                                    wav_phase = (wav_skip == 0) ? rwps_pkg::PH_CTAG
                                                                : rwps_pkg::PH_SKIP;
                                end
                            end
                            rwps_pkg::PH_CTAG: begin
                                wav_phase = (v == rwps_pkg::TAG_DATA) ? rwps_pkg::PH_DSIZE
                                                                      : rwps_pkg::PH_CSIZE;
                            end
                            rwps_pkg::PH_CSIZE: begin
                                sz = v;
                                if (sz[0] && sz != '1) sz = sz + 1;
                                wav_skip  = sz;
                                wav_phase = (sz == 0) ? rwps_pkg::PH_CTAG : rwps_pkg::PH_SKIP;
                            end
                            rwps_pkg::PH_DSIZE: begin
                                frame = 32'(wav_chans) * 32'(wav_bits >> 3);
                                if (frame == 0) begin
                                    fault = rwps_pkg::ERR_UNSUP;
                                end else begin
                                    wav_left      = v - (v % frame);
                                    wav_chan      = '0;
                                    wav_phase     = rwps_pkg::PH_DATA;
                                    have          = 1'b1;
                                    r.kind        = rwps_pkg::KIND_FORMAT;
                                    r.channels    = wav_chans;
                                    r.sample_rate = wav_rate;
                                    r.sample_bits = wav_bits;
                                    r.last        = (wav_left == 0);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
        end
        if (fault != rwps_pkg::ERR_NONE) begin
            r        = fault_beat(fault);
            have     = 1'b1;
            wav_dead = 1'b1;
        end
        if (eos) begin
            if (!(have && r.last) &&
                !(wav_dead || (wav_phase == rwps_pkg::PH_DATA && wav_left == 0))) begin
                r    = fault_beat(rwps_pkg::ERR_TRUNC);
                have = 1'b1;
            end
            wav_reset();
        end
        return have;
    endfunction

    function automatic void put_le(input logic [31:0] w, input int n);
        int k;
        for (k = 0; k < n; k++) file_q.push_back(w[8*k +: 8]);
    endfunction

    function automatic void build_file(input t_wav_spec f, input bit rails);
        logic [32:0] ext;
        logic [31:0] jtag;
        int          n;
        int          k;
        file_q.delete();
        put_le(f.bad_tag == 1 ? rwps_pkg::TAG_RIFF ^ 32'h0100_0000 : rwps_pkg::TAG_RIFF, 4);
        put_le($urandom, 4);
        put_le(f.bad_tag == 2 ? rwps_pkg::TAG_WAVE ^ 32'h0100_0000 : rwps_pkg::TAG_WAVE, 4);
        put_le(f.bad_tag == 3 ? rwps_pkg::TAG_FMT ^ 32'h0100_0000 : rwps_pkg::TAG_FMT, 4);
        put_le(f.fsize, 4);
        put_le(32'(f.code), 2);
        put_le(32'(f.chans), 2);
        put_le(f.rate, 4);
        put_le($urandom, 4);
        put_le($urandom, 2);
        put_le(32'(f.bits), 2);
        ext = (f.fsize > 16) ? 33'(f.fsize) - 33'd16 + 33'(f.fsize[0]) : '0;
        n = (ext > 64) ? 64 : int'(ext);
        repeat (n) put_le($urandom, 1);
        if (f.junk) begin
            jtag = $urandom;
            if (jtag == rwps_pkg::TAG_DATA) jtag = ~jtag;
            put_le(jtag, 4);
            put_le(f.jsize, 4);
            ext = 33'(f.jsize) + 33'(f.jsize[0] && f.jsize != '1);
            n = (ext > 64) ? 64 : int'(ext);
            repeat (n) put_le($urandom, 1);
        end
        put_le(rwps_pkg::TAG_DATA, 4);
        put_le(f.dsize, 4);
        for (k = 0; k < f.dbytes; k++)
            put_le(32'(rails ? RAIL_BYTES[k % 5] : 8'($urandom)), 1);
    endfunction

    function automatic t_wav_spec rand_spec();
        t_wav_spec s;
        int        frame;
        s.bad_tag = 0;
        s.fsize   = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 24)) : 32'd16;
        s.code    = 16'd1;
        s.chans   = 16'($urandom_range(1, rwps_pkg::CHAN_MAX));
        s.rate    = $urandom;
        s.bits    = 16'(8 * $urandom_range(1, 3));
        s.junk    = ($urandom_range(0, 2) == 0);
        s.jsize   = $urandom_range(0, 20);
        frame     = int'(s.chans) * int'(s.bits) / 8;
        s.dsize   = frame * $urandom_range(0, 72 / frame) + $urandom_range(0, frame - 1);
        s.dbytes  = int'(s.dsize) + $urandom_range(0, 3);
        s.cut     = -1;
        s.typed   = rwps_pkg::ERR_NONE;
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 4))
                0:       s.cut = $urandom_range(1, 120);
                1:       s.bad_tag = $urandom_range(1, 3);
                2:       s.code = 16'($urandom);
                3:       s.chans = 16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 9));
                default: s.bits = 16'($urandom_range(0, 40));
            endcase
        end
        return s;
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit eos);
        int                gap;
        bit                have;
        rwps_pkg::t_result r;
        gap = burst ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_in_byte       <= b;
        i_end_of_stream <= eos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        have = parse_byte(b, eos, r);
        if (have && r.kind == rwps_pkg::KIND_ERROR && row_fault != rwps_pkg::ERR_NONE)
            r = fault_beat(row_fault);
        if (have) pending_results.push_back(r);
        bytes_sent++;
    endtask

    task automatic send_file(input int cut);
        int n;
        int j;
        n = (cut > 0 && cut < file_q.size()) ? cut : file_q.size();
        for (j = 0; j < n; j++) send_byte(file_q[j], j == n - 1);
    endtask

    // drop valid and hold until every pending result has been taken
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    initial begin
        int                beats_taken;
        int                k;
        bit                quiet;
        rwps_pkg::t_result want;
        beats_taken = 0;
        quiet = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (beats_taken % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
            if (beats_taken % 640 == 60) k = 400;
            else k = quiet ? 0 : $urandom_range(0, 16);
            if (k > 0) begin
                i_stall <= 1'b1;
                repeat (k) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending: kind %0d", o_kind);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_kind));
                check_field("sample_value", want.sample_value, o_sample_value);
                check_field("channel_index", 32'(want.channel_index), 32'(o_channel_index));
                check_field("channels", 32'(want.channels), 32'(o_channels));
                check_field("sample_rate", want.sample_rate, o_sample_rate);
                check_field("sample_bits", 32'(want.sample_bits), 32'(o_sample_bits));
                check_field("error_code", 32'(want.error_code), 32'(o_error_code));
                check_field("last", 32'(want.last), 32'(o_last));
            end
            beats_taken++;
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("** riff_wave_pcm_stream_parser_unit: FAILED **");
        $finish;
    end

    initial begin
        t_wav_spec plan[$];
        t_wav_spec s;
        int        files;
        int        start;
        int        n;
        wav_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan.push_back('{1, 16, 1, 1, 8000, 16, 0, 0, 4, 4, -1, rwps_pkg::ERR_RIFF});
        plan.push_back('{2, 16, 1, 1, 8000, 16, 0, 0, 4, 4, -1, rwps_pkg::ERR_WAVE});
        plan.push_back('{3, 16, 1, 1, 8000, 16, 0, 0, 4, 4, -1, rwps_pkg::ERR_FMT});
        plan.push_back('{0, 16, 3, 1, 8000, 16, 0, 0, 4, 4, -1, rwps_pkg::ERR_PCM});
        plan.push_back('{0, 16, 16'hFFFF, 16'hFFFF, 8000, 16, 0, 0, 4, 4, -1,
                         rwps_pkg::ERR_PCM});
        plan.push_back('{0, 16, 1, 0, 8000, 16, 0, 0, 4, 4, -1, rwps_pkg::ERR_UNSUP});
        plan.push_back('{0, 16, 1, 9, 8000, 16, 0, 0, 4, 4, -1, rwps_pkg::ERR_UNSUP});
        plan.push_back('{0, 16, 1, 2, 8000, 32, 0, 0, 4, 4, -1, rwps_pkg::ERR_UNSUP});
        plan.push_back('{0, 16, 1, 2, 8000, 0, 0, 0, 4, 4, -1, rwps_pkg::ERR_UNSUP});
        plan.push_back('{0, 16, 1, 1, 0, 8, 0, 0, 10, 10, -1, rwps_pkg::ERR_NONE});
        plan.push_back('{0, 16, 1, 8, 32'hFFFF_FFFF, 24, 0, 0, 48, 48, -1, rwps_pkg::ERR_NONE});
        plan.push_back('{0, 19, 1, 2, 44100, 16, 1, 5, 8, 8, -1, rwps_pkg::ERR_NONE});
        plan.push_back('{0, 10, 1, 1, 22050, 16, 0, 0, 6, 6, -1, rwps_pkg::ERR_NONE});
        plan.push_back('{0, 16, 1, 3, 48000, 8, 1, 0, 0, 0, -1, rwps_pkg::ERR_NONE});
        plan.push_back('{0, 16, 1, 2, 16000, 16, 0, 0, 7, 9, -1, rwps_pkg::ERR_NONE});
        plan.push_back('{0, 16, 1, 1, 8000, 8, 1, 32'hFFFF_FFFF, 4, 4, 60, rwps_pkg::ERR_TRUNC});
        plan.push_back('{0, 16, 1, 1, 8000, 16, 0, 0, 20, 20, 50, rwps_pkg::ERR_TRUNC});
        plan.push_back('{0, 16, 1, 1, 8000, 16, 0, 0, 4, 4, 1, rwps_pkg::ERR_TRUNC});
        plan.push_back('{1, 16, 1, 1, 8000, 16, 0, 0, 4, 4, 4, rwps_pkg::ERR_RIFF});
        plan.push_back('{0, 16, 1, 1, 11025, 8, 0, 0, 32'hFFFF_FFFF, 12, -1,
                         rwps_pkg::ERR_TRUNC});
        plan.push_back('{0, 16, 1, 2, 96000, 24, 0, 0, 12, 12, 47, rwps_pkg::ERR_TRUNC});
        plan.push_back('{0, 32'hFFFF_FFFF, 1, 1, 8000, 16, 0, 0, 4, 4, 40, rwps_pkg::ERR_TRUNC});
        plan.push_back('{0, 16, 1, 8, 192000, 8, 0, 0, 16, 16, -1, rwps_pkg::ERR_NONE});

        foreach (plan[i]) begin
            row_fault = plan[i].typed;
            burst = ($urandom_range(0, 3) == 0);
            build_file(plan[i], 1'b1);
            send_file(plan[i].cut);
        end
        drain();

        row_fault = rwps_pkg::ERR_NONE;
        files = 0;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 11) == 0) begin
                file_q.delete();
                n = $urandom_range(1, 24);
                repeat (n) file_q.push_back(8'($urandom));
                send_file(-1);
            end else begin
                s = rand_spec();
                build_file(s, 1'b0);
                if ($urandom_range(0, 9) == 0)
                    file_q[$urandom_range(0, file_q.size() - 1)] ^= 8'($urandom_range(1, 255));
                send_file(s.cut);
            end
            files++;
            if (files % 10 == 0) drain();
        end
        drain();
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("** riff_wave_pcm_stream_parser_unit: PASSED **");
        end else begin
            $display("** riff_wave_pcm_stream_parser_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== riff_wave_pcm_stream_parser_unit.f =====
hw/rtl/rwps_pkg.sv
hw/rtl/rwps_parse.sv
hw/rtl/rwps_skid.sv
hw/rtl/riff_wave_pcm_stream_parser_unit.sv
sim/riff_wave_pcm_stream_parser_unit_test.sv
